FILE: sv/slr_pkg.sv
// Shared types, opcodes and constants of the stepper speed ramp generator.
package slr_pkg;

    // Datapath opcodes; the controller's program counter holds them directly.
    typedef logic [4:0] t_op;

    localparam t_op OP_NONE    = 5'd0;
    localparam t_op OP_TICK    = 5'd1;
    localparam t_op OP_RNDIV   = 5'd2;
    localparam t_op OP_RNFIN   = 5'd3;
    localparam t_op OP_MVDIR   = 5'd4;
    localparam t_op OP_D_LEAST = 5'd5;
    localparam t_op OP_W_LEAST = 5'd6;
    localparam t_op OP_D_X     = 5'd7;
    localparam t_op OP_SQRT    = 5'd8;
    localparam t_op OP_M_C0    = 5'd9;
    localparam t_op OP_D_C0    = 5'd10;
    localparam t_op OP_W_C0    = 5'd11;
    localparam t_op OP_M_T     = 5'd12;
    localparam t_op OP_D_T     = 5'd13;
    localparam t_op OP_M_SS    = 5'd14;
    localparam t_op OP_D_MSL   = 5'd15;
    localparam t_op OP_M_SD    = 5'd16;
    localparam t_op OP_D_AL    = 5'd17;
    localparam t_op OP_W_AL    = 5'd18;
    localparam t_op OP_M_MA    = 5'd19;
    localparam t_op OP_D_MA    = 5'd20;
    localparam t_op OP_W_NEG   = 5'd21;
    localparam t_op OP_W_SUB   = 5'd22;
    localparam t_op OP_FIN     = 5'd23;

    // Ramp phases
    localparam logic [1:0] PH_STOP  = 2'd0;
    localparam logic [1:0] PH_ACCEL = 2'd1;
    localparam logic [1:0] PH_DECEL = 2'd2;
    localparam logic [1:0] PH_RUN   = 2'd3;

    // Coil drive patterns by sequence phase
    localparam logic [3:0] COIL_0 = 4'd9;
    localparam logic [3:0] COIL_1 = 4'd5;
    localparam logic [3:0] COIL_2 = 4'd6;
    localparam logic [3:0] COIL_3 = 4'd10;

    localparam int QW = 48;        // divider and product width
    localparam int VW = QW + 2;    // signed width for delay arithmetic

    localparam logic [31:0] K_LEAST_NUM = 32'd314159;
    localparam logic [31:0] K_ACC_NUM   = 32'd628318000;
    localparam logic [31:0] K_C0_MUL    = 32'd676;
    localparam logic [31:0] K_T_MUL     = 32'd628;
    // ceil(2^29 / 25): x / 100 = ((x >> 2) * K_RCP25) >> 29, exact for x < 2^26
    localparam logic [24:0] K_RCP25     = 25'd21474837;
    localparam logic [15:0] K_ONE_STEP  = 16'd1000;
    localparam logic [31:0] SQ_BIT0     = 32'h4000_0000;
    localparam logic [4:0]  SQ_STEPS    = 5'd16;

    typedef struct packed {
        logic ld;
        logic push;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic       busy;
        logic [1:0] phase;
        logic       short_move;
        logic       al_le;
        logic       out_free;
    } t_stat;

    function automatic logic [3:0] coil_of(input logic [1:0] ph);
        case (ph)
            2'd0:    return COIL_0;
            2'd1:    return COIL_1;
            2'd2:    return COIL_2;
            default: return COIL_3;
        endcase
    endfunction

    function automatic logic is_long(input t_op op);
        return (op == OP_D_LEAST) || (op == OP_D_X) || (op == OP_SQRT) ||
               (op == OP_D_MSL) || (op == OP_D_AL) || (op == OP_D_MA) ||
               (op == OP_RNDIV);
    endfunction

endpackage

FILE: sv/slr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module slr_div #(
    parameter int W = 48
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_busy,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_quo, r_rem, r_dsr;
    logic [W:0]    sh, diff;

    assign sh   = {r_rem, r_quo[W-1]};
    assign diff = sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= sh[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

FILE: sv/slr_dp.sv
// Ramp datapath: motion state, shared multiplier, divider, square root, output register.
module slr_dp #(
    parameter int DW = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  slr_pkg::t_cmd        i_cmd,
    input  logic signed [23:0]   i_move_steps,
    input  logic [15:0]          i_accel_rate,
    input  logic [15:0]          i_decel_rate,
    input  logic [15:0]          i_max_speed,
    input  logic                 i_stall,
    output slr_pkg::t_stat       o_stat,
    output logic                 o_valid,
    output logic                 o_stepped,
    output logic [3:0]           o_coil_pattern,
    output logic [DW-1:0]        o_next_delay,
    output logic [1:0]           o_ramp_state,
    output logic                 o_direction
);
    import slr_pkg::*;

    localparam logic signed [VW-1:0] DMAX = VW'((64'd1 << DW) - 64'd1);

    function automatic logic [DW-1:0] sat(input logic signed [VW-1:0] v);
        if (v < 0) return '0;
        if (v > DMAX) return '1;
        return v[DW-1:0];
    endfunction

    // captured transaction
    logic [23:0] r_steps_raw;
    logic [15:0] r_accel_raw, r_decel_raw, r_speed_raw;
    logic [15:0] acc, dec, spd;
    logic [23:0] mag;

    // motion state
    logic [1:0]        r_phase, n_phase, r_seq, n_seq;
    logic              r_dir, n_dir, r_stepped, n_stepped;
    logic [DW-1:0]     r_cur, n_cur, r_least, n_least, r_lap, n_lap;
    logic [23:0]       r_db, n_db, r_sd, n_sd, sd_inc;
    logic signed [31:0] r_dc, n_dc, r_rc, n_rc;
    logic [31:0]       r_rem, n_rem;

    // work registers
    logic [QW-1:0]     r_prod, n_prod, prod;
    logic [31:0]       r_t, n_t, r_msl, n_msl, mul_a;
    logic [15:0]       mul_b;
    logic [23:0]       r_al, n_al;
    logic signed [48:0] r_dval, n_dval, dv;
    logic              r_den_neg, n_den_neg;

    // divide by 100 through reciprocal multiplication
    logic [48:0]       q100_prod;
    logic [31:0]       q100, r_q100, n_q100;

    // divider
    logic              div_start, div_busy;
    logic [QW-1:0]     div_nd, div_ds, div_quo, div_rem, al_new;
    logic signed [33:0] den_s, den_mag;
    logic signed [VW-1:0] qx, qs, diff;
    logic [DW-1:0]     nd;

    // square root
    logic [31:0]       r_sq_rem, r_sq_root, r_sq_bit, sq_sum;
    logic [4:0]        r_sq_cnt;
    logic              r_sq_act;

    // output register
    logic              r_o_vld, r_o_stepped, r_o_dir;
    logic [3:0]        r_o_coil;
    logic [DW-1:0]     r_o_delay;
    logic [1:0]        r_o_state;

    assign acc = (r_accel_raw == 16'd0) ? 16'd1 : r_accel_raw;
    assign dec = (r_decel_raw == 16'd0) ? 16'd1 : r_decel_raw;
    assign spd = (r_speed_raw == 16'd0) ? 16'd1 : r_speed_raw;
    assign mag = r_steps_raw[23] ? (~r_steps_raw + 24'd1) : r_steps_raw;

    assign sd_inc  = r_sd + 24'd1;
    assign den_s   = {r_rc, 2'b01};
    assign den_mag = r_rc[31] ? -den_s : den_s;
    assign qx      = $signed({2'b00, div_quo});
    assign qs      = r_den_neg ? -qx : qx;
    assign diff    = $signed({{(VW-DW){1'b0}}, r_cur}) - qs;
    assign nd      = sat(diff);
    assign al_new  = (div_quo == '0) ? QW'(1) : div_quo;
    assign dv      = (r_dval == '0) ? -49'sd1 : r_dval;
    assign prod    = {16'b0, mul_a} * {32'b0, mul_b};
    assign sq_sum  = r_sq_root + r_sq_bit;

    assign q100_prod = {25'b0, r_prod[25:2]} * {24'b0, K_RCP25};
    assign q100      = {12'b0, q100_prod[48:29]};

    slr_div #(.W(QW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_nd),
        .i_divisor  (div_ds),
        .o_busy     (div_busy),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_phase   = r_phase;
        n_seq     = r_seq;
        n_dir     = r_dir;
        n_stepped = r_stepped;
        n_cur     = r_cur;
        n_least   = r_least;
        n_lap     = r_lap;
        n_db      = r_db;
        n_sd      = r_sd;
        n_dc      = r_dc;
        n_rc      = r_rc;
        n_rem     = r_rem;
        n_prod    = r_prod;
        n_t       = r_t;
        n_msl     = r_msl;
        n_al      = r_al;
        n_dval    = r_dval;
        n_den_neg = r_den_neg;
        n_q100    = r_q100;
        div_start = 1'b0;
        div_nd    = '0;
        div_ds    = '0;
        mul_a     = '0;
        mul_b     = '0;
        case (i_cmd.op)
            OP_TICK: begin
                if (r_phase == PH_STOP) begin
                    n_sd      = '0;
                    n_rem     = '0;
                    n_stepped = 1'b0;
                end else begin
                    n_seq     = r_dir ? (r_seq - 2'd1) : (r_seq + 2'd1);
                    n_sd      = sd_inc;
                    n_stepped = 1'b1;
                    if (r_phase == PH_RUN) begin
                        if (sd_inc >= r_db) begin
                            n_rc    = r_dc;
                            n_cur   = r_lap;
                            n_phase = PH_DECEL;
                        end else begin
                            n_cur = r_least;
                        end
                    end else begin
                        n_rc = r_rc + 32'sd1;
                    end
                end
            end
            OP_RNDIV: begin
                div_start = 1'b1;
                div_nd    = ({{(QW-DW){1'b0}}, r_cur} << 1) + {16'b0, r_rem};
                div_ds    = {{(QW-34){1'b0}}, den_mag};
                n_den_neg = r_rc[31];
            end
            OP_RNFIN: begin
                n_rem = div_rem[31:0];
                if (r_phase == PH_ACCEL) begin
                    if (r_sd >= r_db) begin
                        n_rc    = r_dc;
                        n_phase = PH_DECEL;
                        n_cur   = nd;
                    end else if (nd <= r_least) begin
                        n_lap   = nd;
                        n_cur   = r_least;
                        n_rem   = '0;
                        n_phase = PH_RUN;
                    end else begin
                        n_cur = nd;
                    end
                end else begin
                    n_cur = nd;
                    if (!r_rc[31]) begin
                        n_phase = PH_STOP;
                    end
                end
            end
            OP_MVDIR: begin
                n_dir     = r_steps_raw[23];
                n_stepped = 1'b0;
                if (mag == 24'd1) begin
                    n_rc    = -32'sd1;
                    n_phase = PH_DECEL;
                    n_cur   = DW'(K_ONE_STEP);
                end
            end
            OP_D_LEAST: begin
                div_start = 1'b1;
                div_nd    = QW'(K_LEAST_NUM);
                div_ds    = QW'(spd);
            end
            OP_W_LEAST: n_least = sat(qx);
            OP_D_X: begin
                div_start = 1'b1;
                div_nd    = QW'(K_ACC_NUM);
                div_ds    = QW'(acc);
            end
            OP_M_C0: begin
                mul_a  = K_C0_MUL;
                mul_b  = r_sq_root[15:0];
                n_prod = prod;
            end
            OP_D_C0, OP_D_T: n_q100 = q100;
            OP_W_C0: n_cur = sat($signed({{(VW-32){1'b0}}, r_q100}));
            OP_M_T: begin
                mul_a  = K_T_MUL;
                mul_b  = acc;
                n_prod = prod;
            end
            OP_M_SS: begin
                n_t    = r_q100;
                mul_a  = {16'b0, spd};
                mul_b  = spd;
                n_prod = prod;
            end
            OP_D_MSL: begin
                div_start = 1'b1;
                div_nd    = r_prod;
                div_ds    = QW'(r_t);
            end
            OP_M_SD: begin
                n_msl  = (div_quo == '0) ? 32'd1 : div_quo[31:0];
                mul_a  = {8'b0, mag};
                mul_b  = dec;
                n_prod = prod;
            end
            OP_D_AL: begin
                div_start = 1'b1;
                div_nd    = r_prod;
                div_ds    = QW'({1'b0, acc} + {1'b0, dec});
            end
            OP_W_AL: n_al = al_new[23:0];
            OP_M_MA: begin
                mul_a  = r_msl;
                mul_b  = acc;
                n_prod = prod;
            end
            OP_D_MA: begin
                div_start = 1'b1;
                div_nd    = r_prod;
                div_ds    = QW'(dec);
            end
            OP_W_NEG: n_dval = -$signed({1'b0, div_quo});
            OP_W_SUB: n_dval = $signed({25'b0, r_al}) - $signed({25'b0, mag});
            OP_FIN: begin
                n_dc = dv[31:0];
                n_db = mag + dv[23:0];
                n_rc = '0;
                if (r_cur <= r_least) begin
                    n_cur   = r_least;
                    n_lap   = r_least;
                    n_phase = PH_RUN;
                end else begin
                    n_phase = PH_ACCEL;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_STOP;
            r_seq     <= '0;
            r_dir     <= 1'b0;
            r_stepped <= 1'b0;
            r_cur     <= '0;
            r_least   <= '0;
            r_lap     <= '0;
            r_db      <= '0;
            r_sd      <= '0;
            r_dc      <= '0;
            r_rc      <= '0;
            r_rem     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_seq     <= n_seq;
            r_dir     <= n_dir;
            r_stepped <= n_stepped;
            r_cur     <= n_cur;
            r_least   <= n_least;
            r_lap     <= n_lap;
            r_db      <= n_db;
            r_sd      <= n_sd;
            r_dc      <= n_dc;
            r_rc      <= n_rc;
            r_rem     <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod    <= n_prod;
        r_t       <= n_t;
        r_msl     <= n_msl;
        r_al      <= n_al;
        r_dval    <= n_dval;
        r_den_neg <= n_den_neg;
        r_q100    <= n_q100;
        if (i_cmd.ld) begin
            r_steps_raw <= i_move_steps;
            r_accel_raw <= i_accel_rate;
            r_decel_raw <= i_decel_rate;
            r_speed_raw <= i_max_speed;
        end
    end

    // square root: one root bit per cycle, then round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_act <= 1'b0;
            r_sq_cnt <= '0;
        end else if (i_cmd.op == OP_SQRT) begin
            r_sq_act <= 1'b1;
            r_sq_cnt <= SQ_STEPS;
        end else if (r_sq_act) begin
            if (r_sq_cnt != 5'd0) begin
                r_sq_cnt <= r_sq_cnt - 5'd1;
            end else begin
                r_sq_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SQRT) begin
            r_sq_rem  <= div_quo[31:0];
            r_sq_root <= '0;
            r_sq_bit  <= SQ_BIT0;
        end else if (r_sq_act) begin
            if (r_sq_cnt != 5'd0) begin
                if (sq_sum <= r_sq_rem) begin
                    r_sq_rem  <= r_sq_rem - sq_sum;
                    r_sq_root <= (r_sq_root >> 1) + r_sq_bit;
                end else begin
                    r_sq_root <= r_sq_root >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end else if (r_sq_root < r_sq_rem) begin
                r_sq_root <= r_sq_root + 32'd1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_cmd.push) begin
            r_o_vld <= 1'b1;
        end else if (!i_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_o_stepped <= r_stepped;
            r_o_coil    <= coil_of(r_seq);
            r_o_delay   <= r_cur;
            r_o_state   <= r_phase;
            r_o_dir     <= r_dir;
        end
    end

    assign o_stat.busy       = div_busy | r_sq_act;
    assign o_stat.phase      = r_phase;
    assign o_stat.short_move = (mag <= 24'd1);
    assign o_stat.al_le      = (al_new <= {16'b0, r_msl});
    assign o_stat.out_free   = !r_o_vld || !i_stall;

    assign o_valid        = r_o_vld;
    assign o_stepped      = r_o_stepped;
    assign o_coil_pattern = r_o_coil;
    assign o_next_delay   = r_o_delay;
    assign o_ramp_state   = r_o_state;
    assign o_direction    = r_o_dir;
endmodule

FILE: sv/slr_ctrl.sv
// Ramp controller: sequences datapath operations for move and tick transactions.
module slr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_action,
    input  slr_pkg::t_stat i_stat,
    output logic           o_stall,
    output slr_pkg::t_cmd  o_cmd
);
    import slr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;
    t_op        r_pc, n_pc, pc_next;

    // program order; branches use status from before the current op
    always_comb begin
        case (r_pc)
            OP_TICK:     pc_next = ((i_stat.phase == PH_ACCEL) || (i_stat.phase == PH_DECEL))
                                   ? OP_RNDIV : OP_NONE;
            OP_RNDIV:    pc_next = OP_RNFIN;
            OP_MVDIR:    pc_next = i_stat.short_move ? OP_NONE : OP_D_LEAST;
            OP_D_LEAST:  pc_next = OP_W_LEAST;
            OP_W_LEAST:  pc_next = OP_D_X;
            OP_D_X:      pc_next = OP_SQRT;
            OP_SQRT:     pc_next = OP_M_C0;
            OP_M_C0:     pc_next = OP_D_C0;
            OP_D_C0:     pc_next = OP_W_C0;
            OP_W_C0:     pc_next = OP_M_T;
            OP_M_T:      pc_next = OP_D_T;
            OP_D_T:      pc_next = OP_M_SS;
            OP_M_SS:     pc_next = OP_D_MSL;
            OP_D_MSL:    pc_next = OP_M_SD;
            OP_M_SD:     pc_next = OP_D_AL;
            OP_D_AL:     pc_next = OP_W_AL;
            OP_W_AL:     pc_next = i_stat.al_le ? OP_W_SUB : OP_M_MA;
            OP_M_MA:     pc_next = OP_D_MA;
            OP_D_MA:     pc_next = OP_W_NEG;
            OP_W_NEG:    pc_next = OP_FIN;
            OP_W_SUB:    pc_next = OP_FIN;
            default:     pc_next = OP_NONE;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        o_cmd.ld    = 1'b0;
        o_cmd.push  = 1'b0;
        o_cmd.op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.ld = 1'b1;
                    n_pc     = i_action ? OP_TICK : OP_MVDIR;
                    n_state  = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.op = r_pc;
                n_pc     = pc_next;
                if (is_long(r_pc)) begin
                    n_state = S_WAIT;
                end else if (pc_next == OP_NONE) begin
                    n_state = S_OUT;
                end
            end
            S_WAIT: begin
                if (!i_stat.busy) begin
                    n_state = (r_pc == OP_NONE) ? S_OUT : S_RUN;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= OP_NONE;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    assign o_stall = (r_state != S_IDLE);
endmodule

FILE: sv/stepper_linear_speed_ramp.sv
// Top level of the trapezoidal stepper speed ramp generator.
// Tick transaction: in stop or run no divider pass; in accel or decel one pass of the
// shared 48-bit restoring divider.
// Move transaction: no divider pass for zero or one step, otherwise four passes, or five
// when the top-speed limit sets the decel point, plus the square root.
// One transaction at a time; a stalled result holds back the next result, and so the input.
// Synchronous active-low reset clears the ramp state to stop, delay 0, coil phase 0.
module stepper_linear_speed_ramp #(
    parameter int DELAY_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_action,
    input  logic signed [23:0]     i_move_steps,
    input  logic [15:0]            i_accel_rate,
    input  logic [15:0]            i_decel_rate,
    input  logic [15:0]            i_max_speed,
    // output channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_stepped,
    output logic [3:0]             o_coil_pattern,
    output logic [DELAY_WIDTH-1:0] o_next_delay,
    output logic [1:0]             o_ramp_state,
    output logic                   o_direction
);
    import slr_pkg::*;

    // Command and status between the sequencer and the datapath.
    t_cmd  cmd;
    t_stat stat;

    // Controller: accepts a transaction when idle, walks the operation
    // program for a move or a tick, and pushes the result into the output
    // register once that register is free.
    slr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_stat   (stat),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    // Datapath: holds the ramp state, runs the shared multiplier, divider
    // and square root, and keeps the output register, which holds a
    // result until the downstream side takes it.
    slr_dp #(.DW(DELAY_WIDTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_move_steps   (i_move_steps),
        .i_accel_rate   (i_accel_rate),
        .i_decel_rate   (i_decel_rate),
        .i_max_speed    (i_max_speed),
        .i_stall        (i_stall),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_stepped      (o_stepped),
        .o_coil_pattern (o_coil_pattern),
        .o_next_delay   (o_next_delay),
        .o_ramp_state   (o_ramp_state),
        .o_direction    (o_direction)
    );
endmodule

FILE: sv/slr_chk.sv
// Port-level checker for the stepper speed ramp generator, bound to the top level.
module slr_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [3:0] o_coil_pattern
);
    import slr_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // an accepted transaction keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accept");

    // a new result appears only after the block has been busy
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without work");

    // coil pattern is one of the four drive codes
    a_coil_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_coil_pattern == COIL_0) || (o_coil_pattern == COIL_1) ||
                    (o_coil_pattern == COIL_2) || (o_coil_pattern == COIL_3))
        else $error("bad coil pattern");
endmodule

bind stepper_linear_speed_ramp slr_chk u_slr_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_coil_pattern (o_coil_pattern)
);
